>>> design/dtyp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtyp_pkg;

   // Number of CORDIC micro-rotations per angle unless overridden.
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int MAX_STEPS        = 32;

   // Field and datapath widths.
   localparam int IN_W     = 32;          // Q16.16 position fields
   localparam int DIFF_W   = 33;          // position differences
   localparam int NORM_W   = 38;          // normalized component, signed
   localparam int NORM_TOP = 36;          // largest magnitude lands in [2^36, 2^37)
   localparam int SHIFT_W  = 6;
   localparam int CW       = 42;          // CORDIC x and y
   localparam int ZW       = 26;          // CORDIC angle, units of 2^-16 degree
   localparam int ANG_W    = 17;          // Q8.8 output angle
   localparam int SQ_W     = 16;          // operand width of the distance squares
   localparam int SUM_W    = 34;
   localparam int THR_W    = 32;
   localparam int GAIN_W   = 24;

   // Slightly below 2^24 / K for the converged CORDIC gain K.
   localparam logic [GAIN_W-1:0]       INV_GAIN  = 24'd10187998;
   localparam logic signed [ZW-1:0]    ANG_90    = 26'sd5898240;
   localparam logic signed [ANG_W-1:0] Q88_LIMIT = 17'sd46080;
   localparam logic signed [ANG_W-1:0] Q88_RIGHT = 17'sd23040;

   // atan(2^-i) in units of 2^-16 degree, rounded to nearest.
   localparam int ATAN_TAB [MAX_STEPS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0,
      0, 0, 0, 0, 0, 0, 0, 0
   };

   // Per-item status that rides along the pipeline.
   typedef struct packed {
      logic too_close;
      logic vertical;
      logic yaw_only;
      logic dz_neg;
      logic dz_zero;
   } flags_type;

   // Sideband through the yaw chain.
   typedef struct packed {
      flags_type               flags;
      logic signed [NORM_W-1:0] nz;
   } yaw_side_type;

   // Sideband through the pitch chain.
   typedef struct packed {
      flags_type           flags;
      logic signed [ZW-1:0] yaw_z;
   } pitch_side_type;

endpackage

`default_nettype wire

>>> design/dtyp_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dtyp_cell
   import dtyp_pkg::*;
#(
   parameter int STEP   = 0,
   parameter int SIDE_W = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic signed [CW-1:0] in_x,
   input  wire logic signed [CW-1:0] in_y,
   input  wire logic signed [ZW-1:0] in_z,
   input  wire logic [SIDE_W-1:0]    in_side,
   output logic                      out_valid,
   output logic signed [CW-1:0]      out_x,
   output logic signed [CW-1:0]      out_y,
   output logic signed [ZW-1:0]      out_z,
   output logic [SIDE_W-1:0]         out_side
);

   localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TAB[STEP]);

   logic                 valid_ff;
   logic signed [CW-1:0] x_ff, x_in;
   logic signed [CW-1:0] y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [SIDE_W-1:0]    side_ff;
   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;

   // Arithmetic shifts floor toward minus infinity.
   assign xs = in_x >>> STEP;
   assign ys = in_y >>> STEP;

   // One micro-rotation driving y toward zero.
   always_comb begin
      if (!in_y[CW-1]) begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         z_in = in_z + ATAN;
      end else begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         z_in = in_z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

>>> design/dtyp_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module dtyp_chain
   import dtyp_pkg::*;
#(
   parameter int STEPS  = CORDIC_STEPS_DEF,
   parameter int SIDE_W = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic signed [CW-1:0] in_x,
   input  wire logic signed [CW-1:0] in_y,
   input  wire logic [SIDE_W-1:0]    in_side,
   output logic                      out_valid,
   output logic signed [CW-1:0]      out_x,
   output logic signed [ZW-1:0]      out_z,
   output logic [SIDE_W-1:0]         out_side
);

   logic                 pre_valid_ff;
   logic signed [CW-1:0] pre_x_ff, pre_x_in;
   logic signed [CW-1:0] pre_y_ff, pre_y_in;
   logic signed [ZW-1:0] pre_z_ff, pre_z_in;
   logic [SIDE_W-1:0]    pre_side_ff;

   logic                 v_s    [STEPS+1];
   logic signed [CW-1:0] x_s    [STEPS+1];
   logic signed [CW-1:0] y_s    [STEPS+1];
   logic signed [ZW-1:0] z_s    [STEPS+1];
   logic [SIDE_W-1:0]    side_s [STEPS+1];

   // A vector in the left half-plane is first turned by a quarter turn.
   always_comb begin
      pre_x_in = in_x;
      pre_y_in = in_y;
      pre_z_in = '0;
      if (in_x[CW-1]) begin
         if (!in_y[CW-1]) begin
            pre_x_in = in_y;
            pre_y_in = -in_x;
            pre_z_in = ANG_90;
         end else begin
            pre_x_in = -in_y;
            pre_y_in = in_x;
            pre_z_in = -ANG_90;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (en) begin
         pre_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_x_ff    <= pre_x_in;
         pre_y_ff    <= pre_y_in;
         pre_z_ff    <= pre_z_in;
         pre_side_ff <= in_side;
      end
   end

   assign v_s[0]    = pre_valid_ff;
   assign x_s[0]    = pre_x_ff;
   assign y_s[0]    = pre_y_ff;
   assign z_s[0]    = pre_z_ff;
   assign side_s[0] = pre_side_ff;

   // Row of micro-rotation cells, one step of the vectoring each.
   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      dtyp_cell #(
         .STEP   (i),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (v_s[i]),
         .in_x      (x_s[i]),
         .in_y      (y_s[i]),
         .in_z      (z_s[i]),
         .in_side   (side_s[i]),
         .out_valid (v_s[i+1]),
         .out_x     (x_s[i+1]),
         .out_y     (y_s[i+1]),
         .out_z     (z_s[i+1]),
         .out_side  (side_s[i+1])
      );
   end

   assign out_valid = v_s[STEPS];
   assign out_x     = x_s[STEPS];
   assign out_z     = z_s[STEPS];
   assign out_side  = side_s[STEPS];

endmodule

`default_nettype wire

>>> design/dtyp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dtyp_front
   import dtyp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire logic signed [IN_W-1:0] cam_x,
   input  wire logic signed [IN_W-1:0] cam_y,
   input  wire logic signed [IN_W-1:0] cam_z,
   input  wire logic signed [IN_W-1:0] anchor_x,
   input  wire logic signed [IN_W-1:0] anchor_y,
   input  wire logic signed [IN_W-1:0] anchor_z,
   input  wire logic                   mode,
   input  wire logic [THR_W-1:0]       min_distance_squared,
   output logic                        out_valid,
   output logic signed [CW-1:0]        out_x,
   output logic signed [CW-1:0]        out_y,
   output yaw_side_type                out_side
);

   localparam int GRP_BITS = 8;
   localparam int GROUPS   = (DIFF_W + GRP_BITS - 1) / GRP_BITS;
   localparam int LOC_W    = $clog2(GRP_BITS);
   localparam int POS_W    = $clog2(GROUPS * GRP_BITS);

   // Stage 1: differences.
   logic                     v1_ff;
   logic signed [DIFF_W-1:0] dx1_ff, dy1_ff, dz1_ff;
   logic                     mode1_ff;

   // Stage 2: magnitudes.
   logic                     v2_ff;
   logic signed [DIFF_W-1:0] dx2_ff, dy2_ff, dz2_ff;
   logic [DIFF_W-1:0]        ax2_ff, ay2_ff, az2_ff;
   logic [DIFF_W-1:0]        ax2_in, ay2_in, az2_in;
   logic                     mode2_ff;

   // Stage 3: squares and per-group leading-one search.
   logic                     v3_ff;
   logic signed [DIFF_W-1:0] dx3_ff, dy3_ff, dz3_ff;
   logic [2*SQ_W-1:0]        sqx3_ff, sqy3_ff, sqz3_ff;
   logic                     small3_ff;
   logic                     vertical3_ff, dz_neg3_ff, dz_zero3_ff, mode3_ff;
   logic [GROUPS-1:0]        grp_nz3_ff, grp_nz3_in;
   logic [LOC_W-1:0]         grp_loc3_ff [GROUPS];
   logic [LOC_W-1:0]         grp_loc3_in [GROUPS];
   logic [GROUPS*GRP_BITS-1:0] orv;

   // Stage 4: threshold compare and shift amount.
   logic                     v4_ff;
   logic signed [DIFF_W-1:0] dx4_ff, dy4_ff, dz4_ff;
   flags_type                flags4_ff, flags4_in;
   logic [SHIFT_W-1:0]       shift4_ff, shift4_in;
   logic [POS_W-1:0]         msb_pos;
   logic [SUM_W-1:0]         sum_sq;

   // Stage 5: normalized components.
   logic                     v5_ff;
   logic signed [CW-1:0]     x5_ff, y5_ff;
   yaw_side_type             side5_ff, side5_in;

   // Valid bits of all stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Magnitude of a 33 bit difference; the most negative value maps to 2^32.
   assign ax2_in = dx1_ff[DIFF_W-1] ? $unsigned(-dx1_ff) : $unsigned(dx1_ff);
   assign ay2_in = dy1_ff[DIFF_W-1] ? $unsigned(-dy1_ff) : $unsigned(dy1_ff);
   assign az2_in = dz1_ff[DIFF_W-1] ? $unsigned(-dz1_ff) : $unsigned(dz1_ff);

   // The OR of the magnitudes has its top bit where the largest one has.
   assign orv = (GROUPS*GRP_BITS)'(ax2_ff | ay2_ff | az2_ff);

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_nz3_in[g]  = |orv[g*GRP_BITS +: GRP_BITS];
         grp_loc3_in[g] = '0;
         for (int b = 0; b < GRP_BITS; b++) begin
            if (orv[g*GRP_BITS + b]) begin
               grp_loc3_in[g] = LOC_W'(b);
            end
         end
      end
   end

   // The highest group with a set bit gives the leading-one position.
   always_comb begin
      msb_pos = '0;
      for (int g = 0; g < GROUPS; g++) begin
         if (grp_nz3_ff[g]) begin
            msb_pos = POS_W'(g * GRP_BITS) + POS_W'(grp_loc3_ff[g]);
         end
      end
      shift4_in = SHIFT_W'(NORM_TOP) - SHIFT_W'(msb_pos);
   end

   // Any magnitude of 2^16 or more already squares past every threshold.
   assign sum_sq = SUM_W'(sqx3_ff) + SUM_W'(sqy3_ff) + SUM_W'(sqz3_ff);

   always_comb begin
      flags4_in.too_close = small3_ff && (sum_sq < SUM_W'(min_distance_squared));
      flags4_in.vertical  = vertical3_ff;
      flags4_in.yaw_only  = mode3_ff;
      flags4_in.dz_neg    = dz_neg3_ff;
      flags4_in.dz_zero   = dz_zero3_ff;
   end

   always_comb begin
      side5_in.flags = flags4_ff;
      side5_in.nz    = NORM_W'(dz4_ff) <<< shift4_ff;
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff   <= DIFF_W'(cam_x) - DIFF_W'(anchor_x);
         dy1_ff   <= DIFF_W'(cam_y) - DIFF_W'(anchor_y);
         dz1_ff   <= DIFF_W'(cam_z) - DIFF_W'(anchor_z);
         mode1_ff <= mode;

         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
         dz2_ff   <= dz1_ff;
         ax2_ff   <= ax2_in;
         ay2_ff   <= ay2_in;
         az2_ff   <= az2_in;
         mode2_ff <= mode1_ff;

         dx3_ff       <= dx2_ff;
         dy3_ff       <= dy2_ff;
         dz3_ff       <= dz2_ff;
         sqx3_ff      <= (2*SQ_W)'(ax2_ff[SQ_W-1:0]) * (2*SQ_W)'(ax2_ff[SQ_W-1:0]);
         sqy3_ff      <= (2*SQ_W)'(ay2_ff[SQ_W-1:0]) * (2*SQ_W)'(ay2_ff[SQ_W-1:0]);
         sqz3_ff      <= (2*SQ_W)'(az2_ff[SQ_W-1:0]) * (2*SQ_W)'(az2_ff[SQ_W-1:0]);
         small3_ff    <= (ax2_ff[DIFF_W-1:SQ_W] == '0) && (ay2_ff[DIFF_W-1:SQ_W] == '0)
                         && (az2_ff[DIFF_W-1:SQ_W] == '0);
         vertical3_ff <= (ax2_ff == '0) && (ay2_ff == '0);
         dz_neg3_ff   <= dz2_ff[DIFF_W-1];
         dz_zero3_ff  <= (az2_ff == '0);
         mode3_ff     <= mode2_ff;
         grp_nz3_ff   <= grp_nz3_in;
         grp_loc3_ff  <= grp_loc3_in;

         dx4_ff    <= dx3_ff;
         dy4_ff    <= dy3_ff;
         dz4_ff    <= dz3_ff;
         flags4_ff <= flags4_in;
         shift4_ff <= shift4_in;

         x5_ff    <= CW'(NORM_W'(dx4_ff) <<< shift4_ff);
         y5_ff    <= CW'(NORM_W'(dy4_ff) <<< shift4_ff);
         side5_ff <= side5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_x     = x5_ff;
   assign out_y     = y5_ff;
   assign out_side  = side5_ff;

endmodule

`default_nettype wire

>>> design/dtyp_gain.sv
`timescale 1ns / 1ps
`default_nettype none

module dtyp_gain
   import dtyp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic signed [CW-1:0] in_x,
   input  wire logic signed [ZW-1:0] in_z,
   input  wire yaw_side_type         in_side,
   output logic                      out_valid,
   output logic signed [CW-1:0]      out_x,
   output logic signed [CW-1:0]      out_y,
   output pitch_side_type            out_side
);

   localparam int XU_W   = CW - 1;
   localparam int LO_W   = 21;
   localparam int HI_W   = XU_W - LO_W;
   localparam int PROD_W = XU_W + GAIN_W;

   logic                     v1_ff, v2_ff;
   logic [XU_W-1:0]          xu;
   logic [LO_W+GAIN_W-1:0]   pl1_ff;
   logic [HI_W+GAIN_W-1:0]   ph1_ff;
   logic signed [NORM_W-1:0] nz1_ff;
   pitch_side_type           side1_ff;
   logic [PROD_W-1:0]        prod;
   logic signed [CW-1:0]     x2_ff, y2_ff;
   pitch_side_type           side2_ff;

   // A negative final x counts as zero.
   assign xu = in_x[CW-1] ? '0 : in_x[XU_W-1:0];

   // Product split in two halves so that each multiplier stays narrow.
   assign prod = ({ph1_ff, LO_W'(0)}) + PROD_W'(pl1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pl1_ff         <= (LO_W+GAIN_W)'(xu[LO_W-1:0]) * (LO_W+GAIN_W)'(INV_GAIN);
         ph1_ff         <= (HI_W+GAIN_W)'(xu[XU_W-1:LO_W]) * (HI_W+GAIN_W)'(INV_GAIN);
         nz1_ff         <= in_side.nz;
         side1_ff.flags <= in_side.flags;
         side1_ff.yaw_z <= in_z;

         x2_ff    <= CW'(prod[PROD_W-1:GAIN_W]);
         y2_ff    <= -CW'(nz1_ff);
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_x     = x2_ff;
   assign out_y     = y2_ff;
   assign out_side  = side2_ff;

endmodule

`default_nettype wire

>>> design/direction_to_yaw_pitch.sv
// Throughput: one transfer per cycle while the skid register is empty; the yaw and pitch
// CORDIC rows and every other stage are fully pipelined, and a skid register behind the
// output holds a result while rsp_tready is low; while it is full, req_tready is low.
// Reset (synchronous, active high) empties the pipeline and the output registers and sets
// min_distance_squared to 1, so that only the zero vector counts as too close.
`timescale 1ns / 1ps
`default_nettype none

module direction_to_yaw_pitch
   import dtyp_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // cam_x, cam_y, cam_z, anchor_x, anchor_y, anchor_z (32 bits each).
   input  wire logic [191:0] req_tdata,
   // mode.
   input  wire logic [0:0]   req_tuser,
   // Result channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pitch_deg (17 bits), yaw_deg (17 bits), 6 bits of zero fill.
   output logic [39:0]       rsp_tdata,
   // updated.
   output logic [0:0]        rsp_tuser,
   // Threshold register write.
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [31:0]  csr_data
);

   localparam int RSP_DATA_W = 40;
   localparam int Q88_FRAC   = 8;

   typedef struct packed {
      logic                    updated;
      logic signed [ANG_W-1:0] yaw;
      logic signed [ANG_W-1:0] pitch;
   } result_type;

   logic [THR_W-1:0]     thr_ff;
   logic                 en;

   logic signed [IN_W-1:0] cam_x, cam_y, cam_z, anchor_x, anchor_y, anchor_z;

   logic                 f_valid;
   logic signed [CW-1:0] f_x, f_y;
   yaw_side_type         f_side;

   logic                 y_valid;
   logic signed [CW-1:0] y_x;
   logic signed [ZW-1:0] y_z;
   yaw_side_type         y_side;

   logic                 g_valid;
   logic signed [CW-1:0] g_x, g_y;
   pitch_side_type       g_side;

   logic                 p_valid;
   logic signed [ZW-1:0] p_z;
   pitch_side_type       p_side;

   result_type           tail;
   result_type           rsp_ff;
   result_type           skid_ff;
   logic                 rsp_valid_ff;
   logic                 skid_valid_ff;

   // Degrees in 2^-16 units to Q8.8, rounding half up and clamping to half a turn.
   function automatic logic signed [ANG_W-1:0] to_q88(input logic signed [ZW-1:0] z);
      logic signed [ZW:0]          r;
      logic signed [ZW-Q88_FRAC:0] q;
      r = (ZW+1)'(z) + (ZW+1)'(1 << (Q88_FRAC - 1));
      q = $signed(r[ZW:Q88_FRAC]);
      if (q > Q88_LIMIT) begin
         return Q88_LIMIT;
      end else if (q < -Q88_LIMIT) begin
         return -Q88_LIMIT;
      end
      return ANG_W'(q);
   endfunction

   // Threshold register; always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(1);
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // The whole pipeline moves while the skid register is free.
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   assign cam_x    = req_tdata[IN_W-1:0];
   assign cam_y    = req_tdata[2*IN_W-1:IN_W];
   assign cam_z    = req_tdata[3*IN_W-1:2*IN_W];
   assign anchor_x = req_tdata[4*IN_W-1:3*IN_W];
   assign anchor_y = req_tdata[5*IN_W-1:4*IN_W];
   assign anchor_z = req_tdata[6*IN_W-1:5*IN_W];

   dtyp_front u_front (
      .clock                (clock),
      .reset                (reset),
      .en                   (en),
      .in_valid             (req_tvalid),
      .cam_x                (cam_x),
      .cam_y                (cam_y),
      .cam_z                (cam_z),
      .anchor_x             (anchor_x),
      .anchor_y             (anchor_y),
      .anchor_z             (anchor_z),
      .mode                 (req_tuser[0]),
      .min_distance_squared (thr_ff),
      .out_valid            (f_valid),
      .out_x                (f_x),
      .out_y                (f_y),
      .out_side             (f_side)
   );

   // Yaw: angle of (dx, dy).
   dtyp_chain #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W ($bits(yaw_side_type))
   ) u_yaw (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_x      (f_x),
      .in_y      (f_y),
      .in_side   (f_side),
      .out_valid (y_valid),
      .out_x     (y_x),
      .out_z     (y_z),
      .out_side  (y_side)
   );

   // Gain removal turns the yaw row's final x into the horizontal length.
   dtyp_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (y_valid),
      .in_x      (y_x),
      .in_z      (y_z),
      .in_side   (y_side),
      .out_valid (g_valid),
      .out_x     (g_x),
      .out_y     (g_y),
      .out_side  (g_side)
   );

   // Pitch: angle of (hypot, -dz).
   dtyp_chain #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W ($bits(pitch_side_type))
   ) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_valid),
      .in_x      (g_x),
      .in_y      (g_y),
      .in_side   (g_side),
      .out_valid (p_valid),
      .out_x     (),
      .out_z     (p_z),
      .out_side  (p_side)
   );

   // Final result with the too-close, vertical and yaw-only cases applied.
   always_comb begin
      tail.updated = !p_side.flags.too_close;
      tail.yaw     = '0;
      tail.pitch   = '0;
      if (!p_side.flags.too_close) begin
         if (p_side.flags.vertical) begin
            if (!p_side.flags.yaw_only && !p_side.flags.dz_zero) begin
               tail.pitch = p_side.flags.dz_neg ? Q88_RIGHT : -Q88_RIGHT;
            end
         end else begin
            tail.yaw = to_q88(p_side.yaw_z);
            if (!p_side.flags.yaw_only) begin
               tail.pitch = to_q88(p_z);
            end
         end
      end
   end

   // Output register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && !rsp_tready) begin
         if (p_valid && en) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= p_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_ff && !rsp_tready) begin
         if (en) begin
            skid_ff <= tail;
         end
      end else if (skid_valid_ff) begin
         rsp_ff <= skid_ff;
      end else begin
         rsp_ff <= tail;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_ff.updated;
   assign rsp_tdata    = {{(RSP_DATA_W - 2*ANG_W){1'b0}}, rsp_ff.yaw, rsp_ff.pitch};

   // The skid register only fills behind a waiting output.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a result while the output is empty");

   // A result leaving the pipeline is always caught by the output side.
   a_tail_caught: assert property (@(posedge clock) disable iff (reset)
      (p_valid && en) |=> rsp_valid_ff)
      else $error("result leaving the pipeline was dropped");

   // A too-close result carries zero angles.
   a_close_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("too-close result carries nonzero angles");

   // Both angles stay within half a turn.
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[2*ANG_W-1:ANG_W]) <= Q88_LIMIT
                      && $signed(rsp_tdata[2*ANG_W-1:ANG_W]) >= -Q88_LIMIT
                      && $signed(rsp_tdata[ANG_W-1:0]) <= Q88_LIMIT
                      && $signed(rsp_tdata[ANG_W-1:0]) >= -Q88_LIMIT))
      else $error("output angle outside the clamp range");

endmodule

`default_nettype wire

>>> test/direction_to_yaw_pitch_test.sv
`timescale 1ns / 1ps

module direction_to_yaw_pitch_test;

   localparam int STEPS = 16;
   localparam int LATENCY = 2 * STEPS + 9;
   localparam int MAX_PRINTS = 40;
   localparam int TIMEOUT_NS = 2_000_000;

   // Angles inside the predictor count units of 2^-16 degree.
   localparam longint QUARTER_TURN = 5898240;
   localparam longint Q88_MAX = 46080;
   localparam longint Q88_VERTICAL = 23040;
   localparam logic [63:0] HYPOT_GAIN = 64'd10187998;
   localparam longint ARCTAN [STEPS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115
   };

   // Request modes.
   localparam bit MODE_FULL = 1'b0;
   localparam bit MODE_YAW = 1'b1;

   // One unit in Q16.16.
   localparam longint ONE = 65536;

   typedef enum int {
      SHAPE_RANDOM, SHAPE_WIDE, SHAPE_NO_DX, SHAPE_NO_DY, SHAPE_VERTICAL,
      SHAPE_FLAT, SHAPE_TINY, SHAPE_NEAR
   } shape_type;

   // Packed in the same order as req_tdata: cam x, y, z, then anchor x, y, z.
   typedef struct packed {
      logic [2:0][31:0] anchor;
      logic [2:0][31:0] cam;
      logic             yaw_only;
   } view_item_type;

   typedef struct packed {
      logic        updated;
      logic [16:0] pitch;
      logic [16:0] yaw;
   } facing_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [31:0]  csr_data = '0;

   facing_type  facing_q[$];
   logic [31:0] min_dist_sq = 32'd1;
   int          mismatches = 0;
   int          results_seen = 0;
   int          too_close_seen = 0;
   int          yaw_only_sent = 0;
   int          threshold_writes = 0;
   bit          tx_steady = 1'b0;
   bit          rx_steady = 1'b0;
   int          rx_hold = 0;
   int          stall_left = 0;

   direction_to_yaw_pitch DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Idle length between transfers: mostly none, sometimes short, rarely long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Angle in 2^-16 degree to Q8.8, rounding half up, clamped to +-180.
   function automatic longint deg_q88(input longint ang);
      longint q;
      q = (ang + 128) >>> 8;
      if (q > Q88_MAX) q = Q88_MAX;
      if (q < -Q88_MAX) q = -Q88_MAX;
      return q;
   endfunction

   // CORDIC vectoring: returns the angle of (x, y) and the final x.
   function automatic longint cordic_angle(input longint xin, input longint yin,
                                           output longint xout);
      longint x, y, z, xs, ys, t;
      x = xin;
      y = yin;
      z = 0;
      // Fold the left half-plane onto the right one first.
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = QUARTER_TURN;
         end else begin
            x = -y;
            y = t;
            z = -QUARTER_TURN;
         end
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys;
            y -= xs;
            z += ARCTAN[i];
         end else begin
            x -= ys;
            y += xs;
            z -= ARCTAN[i];
         end
      end
      xout = x;
      return z;
   endfunction

   // Expected result for one request under the current threshold.
   function automatic facing_type predict_facing(input view_item_type it);
      longint      d[3];
      longint      n[3];
      logic [65:0] mag[3];
      logic [65:0] len_sq;
      logic [63:0] peak;
      logic [63:0] hyp;
      longint      ang, xf, spare, yaw, pitch;
      int          sh;
      facing_type  f;
      f = '0;
      yaw = 0;
      pitch = 0;
      for (int k = 0; k < 3; k++) begin
         d[k] = longint'($signed(it.cam[k])) - longint'($signed(it.anchor[k]));
         mag[k] = (d[k] < 0) ? 66'(-d[k]) : 66'(d[k]);
      end
      // The exact sum cannot reach 2^66, so the 66-bit sum never wraps and the
      // compare against a 32-bit threshold is exact.
      len_sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      if (len_sq < 66'(min_dist_sq)) return f;
      if (mag[0] == 0 && mag[1] == 0) begin
         // Straight up or down: no yaw, pitch is a right angle.
         if (!it.yaw_only && mag[2] != 0) pitch = (d[2] < 0) ? Q88_VERTICAL : -Q88_VERTICAL;
      end else begin
         peak = mag[0][63:0];
         if (mag[1][63:0] > peak) peak = mag[1][63:0];
         if (mag[2][63:0] > peak) peak = mag[2][63:0];
         sh = 0;
         while (peak < (64'd1 << 36)) begin
            peak <<= 1;
            sh++;
         end
         for (int k = 0; k < 3; k++) n[k] = d[k] <<< sh;
         ang = cordic_angle(n[0], n[1], xf);
         yaw = deg_q88(ang);
         if (!it.yaw_only) begin
            if (xf < 0) xf = 0;
            hyp = (64'(xf) * HYPOT_GAIN) >> 24;
            ang = cordic_angle(longint'(hyp), -n[2], spare);
            pitch = deg_q88(ang);
         end
      end
      f.updated = 1'b1;
      f.pitch = pitch[16:0];
      f.yaw = yaw[16:0];
      return f;
   endfunction

   // Request with the anchor at the origin and the camera at (dx, dy, dz).
   function automatic view_item_type delta_view(input longint dx, input longint dy,
                                                input longint dz, input bit mode);
      view_item_type it;
      it.anchor = '0;
      it.cam[0] = dx[31:0];
      it.cam[1] = dy[31:0];
      it.cam[2] = dz[31:0];
      it.yaw_only = mode;
      return it;
   endfunction

   function automatic view_item_type full_view(input logic [31:0] cx, input logic [31:0] cy,
                                               input logic [31:0] cz, input logic [31:0] ax,
                                               input logic [31:0] ay, input logic [31:0] az,
                                               input bit mode);
      view_item_type it;
      it.cam[0] = cx;
      it.cam[1] = cy;
      it.cam[2] = cz;
      it.anchor[0] = ax;
      it.anchor[1] = ay;
      it.anchor[2] = az;
      it.yaw_only = mode;
      return it;
   endfunction

   // Signed offset of random magnitude, at most 2^29 either way.
   function automatic logic [31:0] spread();
      logic signed [31:0] v;
      v = $urandom;
      return v >>> $urandom_range(2, 31);
   endfunction

   // Random request of a random shape; anchors stay small enough that the
   // camera never wraps around in the structured shapes.
   function automatic view_item_type random_view();
      view_item_type it;
      shape_type     shape;
      shape = shape_type'($urandom_range(SHAPE_RANDOM, SHAPE_NEAR));
      it.yaw_only = $urandom_range(MODE_FULL, MODE_YAW);
      for (int k = 0; k < 3; k++) begin
         it.anchor[k] = $urandom;
         it.cam[k] = $urandom;
      end
      if (shape > SHAPE_WIDE) begin
         for (int k = 0; k < 3; k++) begin
            it.anchor[k] = $signed($urandom) >>> 2;
            it.cam[k] = it.anchor[k] + spread();
         end
      end
      case (shape)
         SHAPE_NO_DX: it.cam[0] = it.anchor[0];
         SHAPE_NO_DY: it.cam[1] = it.anchor[1];
         SHAPE_VERTICAL: begin
            it.cam[0] = it.anchor[0];
            it.cam[1] = it.anchor[1];
         end
         SHAPE_FLAT: it.cam[2] = it.anchor[2];
         SHAPE_TINY: begin
            for (int k = 0; k < 3; k++) it.cam[k] = it.anchor[k] + $urandom_range(0, 6) - 3;
         end
         SHAPE_NEAR: begin
            for (int k = 0; k < 3; k++) it.cam[k] = it.anchor[k] + ($signed($urandom) >>> 16);
         end
         default: ;
      endcase
      return it;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatches++;
      // Only the first few are printed so a broken build cannot flood the log.
      if (mismatches <= MAX_PRINTS)
         $display("%0t ns: %s: expected %0h, got %0h", $time, what, want, got);
   endtask

   // Offer one request and hold it until the transfer, then idle at random.
   task automatic send_view(input view_item_type it);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {it.anchor, it.cam};
      req_tuser <= it.yaw_only;
      do @(posedge clock); while (!req_tready);
      facing_q.push_back(predict_facing(it));
      if (it.yaw_only) yaw_only_sent++;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait for every outstanding result.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (facing_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The threshold only changes while the pipeline is empty.
   task automatic set_threshold(input logic [31:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      min_dist_sq = value;
      threshold_writes++;
   endtask

   // Result side: check every transfer, then decide the next ready level.
   always @(posedge clock) begin
      facing_type want;
      facing_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.updated = rsp_tuser[0];
            got.pitch = rsp_tdata[16:0];
            got.yaw = rsp_tdata[33:17];
            if (facing_q.size() == 0) begin
               report_mismatch("result with nothing outstanding", '0, got);
            end else begin
               want = facing_q.pop_front();
               results_seen++;
               if (!want.updated) too_close_seen++;
               if (got.updated !== want.updated)
                  report_mismatch("updated", want.updated, got.updated);
               if (got.pitch !== want.pitch)
                  report_mismatch("pitch_deg", want.pitch, got.pitch);
               if (got.yaw !== want.yaw)
                  report_mismatch("yaw_deg", want.yaw, got.yaw);
            end
         end
         // A requested long hold-off replaces whatever stall is running.
         if (rx_hold > 0) begin
            stall_left = rx_hold;
            rx_hold = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = rx_steady ? 0 : pick_gap();
         end
      end
   end

   // Axes, half-plane folds, vertical cases, extremes, under the reset threshold.
   task automatic test_directed();
      send_view(delta_view(0, 0, 0, MODE_FULL));
      send_view(delta_view(1, 0, 0, MODE_FULL));
      send_view(delta_view(ONE, 0, 0, MODE_FULL));
      send_view(delta_view(-ONE, 0, 0, MODE_FULL));
      send_view(delta_view(0, ONE, 0, MODE_FULL));
      send_view(delta_view(0, -ONE, 0, MODE_YAW));
      send_view(delta_view(-ONE, -1, 0, MODE_FULL));
      send_view(delta_view(0, 0, ONE, MODE_FULL));
      send_view(delta_view(0, 0, -ONE, MODE_FULL));
      send_view(delta_view(0, 0, ONE, MODE_YAW));
      send_view(delta_view(ONE, ONE, ONE, MODE_FULL));
      send_view(delta_view(-ONE, -ONE, -ONE, MODE_YAW));
      send_view(delta_view(1, 0, -64'sh7FFF_FFFF, MODE_FULL));
      send_view(delta_view(3, -4, 12, MODE_FULL));
      send_view(delta_view(-ONE, 0, ONE, MODE_FULL));
      send_view(full_view('1 >> 1, '1 >> 1, '1 >> 1, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, MODE_FULL));
      send_view(full_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1 >> 1, '1 >> 1,
                          '1 >> 1, MODE_YAW));
      send_view(full_view(32'h8000_0000, '1 >> 1, 32'h8000_0000, '1 >> 1, 32'h8000_0000,
                          '1 >> 1, MODE_FULL));
      send_view(full_view(32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
                          32'h1234_5678, 32'h1234_5678, MODE_FULL));
      send_view(full_view('1, '1, '1, '0, '0, '0, MODE_FULL));
   endtask

   // Lengths just below and at the threshold, including the extreme settings.
   task automatic test_threshold_edges();
      set_threshold(32'd0);
      send_view(delta_view(0, 0, 0, MODE_FULL));
      send_view(delta_view(0, 0, 0, MODE_YAW));
      set_threshold(32'd25);
      send_view(delta_view(3, 4, 0, MODE_FULL));
      send_view(delta_view(3, 3, 2, MODE_FULL));
      send_view(delta_view(-5, 0, 0, MODE_YAW));
      send_view(delta_view(4, -2, 2, MODE_FULL));
      set_threshold(32'hFFFF_FFFF);
      send_view(delta_view(65535, 362, 0, MODE_FULL));
      send_view(delta_view(65535, 363, 0, MODE_FULL));
      send_view(delta_view(ONE, 0, 0, MODE_YAW));
      send_view(delta_view(0, 0, -65535, MODE_FULL));
      send_view(delta_view(ONE, ONE, ONE, MODE_FULL));
   endtask

   // A phase of random requests under one threshold and one idling style.
   task automatic test_random_sweep(input logic [31:0] threshold, input int count,
                                    input bit steady);
      set_threshold(threshold);
      tx_steady = steady;
      rx_steady = steady;
      repeat (count) send_view(random_view());
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   // The result side holds off for a long time while requests keep coming,
   // so the pipeline fills and the request side has to stall.
   task automatic test_output_hold();
      drain_results();
      tx_steady = 1'b1;
      rx_hold = 300;
      repeat (120) send_view(random_view());
      tx_steady = 1'b0;
   endtask

   // The sender stops until every result has come back, then resumes.
   task automatic test_pause_midstream();
      repeat (40) send_view(random_view());
      drain_results();
      repeat (40) send_view(random_view());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_threshold_edges();
      test_random_sweep(32'd1, 340, 1'b0);
      test_random_sweep(32'd0, 340, 1'b1);
      test_random_sweep(32'hFFFF_FFFF, 340, 1'b0);
      test_random_sweep($urandom >> $urandom_range(0, 31), 340, 1'b0);
      test_output_hold();
      test_pause_midstream();
      test_random_sweep($urandom, 340, 1'b0);
      drain_results();
      repeat (LATENCY + 10) @(posedge clock);
      $display("Checked %0d results: %0d too close, %0d yaw-only, %0d threshold writes.",
               results_seen, too_close_seen, yaw_only_sent, threshold_writes);
      $display("Covered axes, vertical and extreme cases, and random traffic with stalls.");
      if (mismatches == 0) begin
         $display("direction_to_yaw_pitch: match");
      end else begin
         $display("direction_to_yaw_pitch: mismatch");
      end
      $finish;
   end

   // Hard limit in case the block stops answering.
   initial begin
      #(TIMEOUT_NS);
      $display("direction_to_yaw_pitch: mismatch");
      $finish;
   end

endmodule
